// File: rtl/tree_kth_ancestor_lifting_assert.svh
// assertion macros for the tree ancestor engine checker
// depends on nothing; included by the checker file
`ifndef TREE_KTH_ANCESTOR_LIFTING_ASSERT_SVH
`define TREE_KTH_ANCESTOR_LIFTING_ASSERT_SVH

// same-cycle implication, disabled in reset
`define TKAL_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("tkal assertion failed");

// next-cycle implication, disabled in reset
`define TKAL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("tkal assertion failed");

// next-cycle implication that also holds through reset
`define TKAL_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("tkal assertion failed");

`endif

// File: rtl/tkal_pkg.sv
// shared constants, codes, types and address helpers for the tree ancestor engine
// depends on nothing
package tkal_pkg;

  localparam int NODES  = 1024;
  localparam int LEVELS = 11;

  localparam int NODE_W   = 10;
  localparam int STEP_W   = 10;
  localparam int DEPTH_W  = 10;
  localparam int STATUS_W = 2;

  localparam int NODE_AW   = $clog2(NODES);
  localparam int LVL_W     = $clog2(LEVELS);
  localparam int TBL_DEPTH = NODES * LEVELS;
  localparam int TBL_AW    = $clog2(TBL_DEPTH);

  localparam logic [DEPTH_W-1:0] DEPTH_MAX = {DEPTH_W{1'b1}};

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic [STATUS_W-1:0] ST_LOAD_OK = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FOUND   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NONE    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD     = 2'd3;

  typedef struct packed {
    logic              kind;
    logic [NODE_W-1:0] node;
    logic [NODE_W-1:0] parent;
    logic [STEP_W-1:0] steps;
  } req_t;

  typedef struct packed {
    logic                valid;
    logic [STATUS_W-1:0] status;
    logic [NODE_W-1:0]   ancestor;
  } res_t;

  typedef struct packed {
    logic               tbl_we;
    logic [TBL_AW-1:0]  tbl_waddr;
    logic [NODE_W-1:0]  tbl_wdata;
    logic [TBL_AW-1:0]  tbl_raddr;
    logic               dep_we;
    logic [NODE_AW-1:0] dep_waddr;
    logic [DEPTH_W-1:0] dep_wdata;
    logic [NODE_AW-1:0] dep_raddr;
  } mem_cmd_t;

  typedef struct packed {
    logic [NODE_W-1:0]  tbl_rdata;
    logic [DEPTH_W-1:0] dep_rdata;
  } mem_rsp_t;

  function automatic logic [TBL_AW-1:0] slot(input logic [NODE_W-1:0] v,
                                             input logic [LVL_W-1:0] j);
    logic [TBL_AW-1:0] base;
    base = TBL_AW'(TBL_AW'(v) * TBL_AW'(LEVELS));
    return base + TBL_AW'(j);
  endfunction

  function automatic logic [NODE_AW-1:0] dep_addr(input logic [NODE_W-1:0] v);
    return NODE_AW'(v);
  endfunction

endpackage

// File: rtl/tkal_in_if.sv
// request channel of the tree ancestor engine: valid, ready and request fields
// depends on tkal_pkg
interface tkal_in_if;
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic [tkal_pkg::NODE_W-1:0] node;
  logic [tkal_pkg::NODE_W-1:0] parent;
  logic [tkal_pkg::STEP_W-1:0] steps;

  modport source (output valid, kind, node, parent, steps, input ready);
  modport sink   (input valid, kind, node, parent, steps, output ready);
endinterface

// File: rtl/tkal_out_if.sv
// result channel of the tree ancestor engine: valid, ready and result fields
// depends on tkal_pkg
interface tkal_out_if;
  logic                          valid;
  logic                          ready;
  logic [tkal_pkg::STATUS_W-1:0] status;
  logic [tkal_pkg::NODE_W-1:0]   ancestor;

  modport source (output valid, status, ancestor, input ready);
  modport sink   (input valid, status, ancestor, output ready);
endinterface

// File: rtl/tkal_store.sv
// lifting table and depth store: one write and one registered read port each,
// write-first forwarding on a same-address read; depends on tkal_pkg
module tkal_store (
  input  logic               clk,
  input  tkal_pkg::mem_cmd_t cmd,
  output tkal_pkg::mem_rsp_t rsp
);

  logic [tkal_pkg::NODE_W-1:0]  tbl_mem [tkal_pkg::TBL_DEPTH];
  logic [tkal_pkg::DEPTH_W-1:0] dep_mem [tkal_pkg::NODES];

  logic [tkal_pkg::NODE_W-1:0]  tbl_q_r;
  logic [tkal_pkg::NODE_W-1:0]  tbl_wd_r;
  logic                         tbl_fwd_r;
  logic [tkal_pkg::DEPTH_W-1:0] dep_q_r;
  logic [tkal_pkg::DEPTH_W-1:0] dep_wd_r;
  logic                         dep_fwd_r;

  always_ff @(posedge clk) begin
    if (cmd.tbl_we) begin
      tbl_mem[cmd.tbl_waddr] <= cmd.tbl_wdata;
    end
    tbl_q_r   <= tbl_mem[cmd.tbl_raddr];
    tbl_wd_r  <= cmd.tbl_wdata;
    tbl_fwd_r <= cmd.tbl_we && (cmd.tbl_waddr == cmd.tbl_raddr);
  end

  always_ff @(posedge clk) begin
    if (cmd.dep_we) begin
      dep_mem[cmd.dep_waddr] <= cmd.dep_wdata;
    end
    dep_q_r   <= dep_mem[cmd.dep_raddr];
    dep_wd_r  <= cmd.dep_wdata;
    dep_fwd_r <= cmd.dep_we && (cmd.dep_waddr == cmd.dep_raddr);
  end

  assign rsp.tbl_rdata = tbl_fwd_r ? tbl_wd_r : tbl_q_r;
  assign rsp.dep_rdata = dep_fwd_r ? dep_wd_r : dep_q_r;

endmodule

// File: rtl/tkal_ctrl.sv
// sequencer of the tree ancestor engine: table fill for loads, lifting walk
// for queries; depends on tkal_pkg and drives tkal_store
module tkal_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               req_fire,
  input  tkal_pkg::req_t     req,
  output logic               req_ready,
  input  logic               out_free,
  output tkal_pkg::res_t     res,
  output tkal_pkg::mem_cmd_t cmd,
  input  tkal_pkg::mem_rsp_t rsp
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ISSUE = 3'd1;
  localparam logic [2:0] S_LIFT  = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  localparam logic [tkal_pkg::LVL_W-1:0] LVL_LAST = tkal_pkg::LVL_W'(tkal_pkg::LEVELS - 1);
  localparam logic [tkal_pkg::LVL_W-1:0] LVL_ONE  = tkal_pkg::LVL_W'(1);

  logic [2:0]                    state_r, state_nxt;
  tkal_pkg::req_t                req_r;
  logic [tkal_pkg::LVL_W-1:0]    j_r, j_nxt;
  logic [tkal_pkg::NODE_W-1:0]   cur_r, cur_nxt;
  logic [tkal_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic [tkal_pkg::NODE_W-1:0]   anc_r, anc_nxt;

  logic                          node_ok;
  logic [tkal_pkg::NODE_W-1:0]   par_eff;
  logic [tkal_pkg::DEPTH_W:0]    dep_sum;
  logic [tkal_pkg::DEPTH_W-1:0]  dep_new;
  logic [31:0]                   steps_sh;
  logic [tkal_pkg::NODE_W-1:0]   cur_eff;

  assign node_ok  = 32'(req_r.node) < tkal_pkg::NODES;
  assign par_eff  = (req_r.node == '0) ? '0 : req_r.parent;
  assign dep_sum  = {1'b0, rsp.dep_rdata} + (tkal_pkg::DEPTH_W + 1)'(1);
  assign dep_new  = (req_r.node == '0) ? '0 :
                    (dep_sum[tkal_pkg::DEPTH_W] ? tkal_pkg::DEPTH_MAX :
                     dep_sum[tkal_pkg::DEPTH_W-1:0]);
  assign steps_sh = 32'(req_r.steps) >> j_r;
  assign cur_eff  = steps_sh[0] ? rsp.tbl_rdata : cur_r;

  assign req_ready  = (state_r == S_IDLE);
  assign res.valid    = (state_r == S_DONE);
  assign res.status   = status_r;
  assign res.ancestor = anc_r;

  always_comb begin
    state_nxt  = state_r;
    j_nxt      = j_r;
    cur_nxt    = cur_r;
    status_nxt = status_r;
    anc_nxt    = anc_r;
    cmd        = '0;
    unique case (state_r)
      S_IDLE: begin
        if (req_fire) begin
          state_nxt = S_ISSUE;
        end
      end
      S_ISSUE: begin
        anc_nxt = '0;
        if (req_r.kind == tkal_pkg::KIND_LOAD) begin
          if (!node_ok || (req_r.node != '0 && req_r.parent >= req_r.node)) begin
            status_nxt = tkal_pkg::ST_BAD;
            state_nxt  = S_DONE;
          end else begin
            cmd.tbl_we    = 1'b1;
            cmd.tbl_waddr = tkal_pkg::slot(req_r.node, '0);
            cmd.tbl_wdata = par_eff;
            cmd.tbl_raddr = tkal_pkg::slot(par_eff, '0);
            cmd.dep_raddr = tkal_pkg::dep_addr(par_eff);
            j_nxt         = LVL_ONE;
            state_nxt     = S_LIFT;
          end
        end else begin
          if (!node_ok) begin
            status_nxt = tkal_pkg::ST_NONE;
            state_nxt  = S_DONE;
          end else begin
            cmd.tbl_raddr = tkal_pkg::slot(req_r.node, '0);
            cmd.dep_raddr = tkal_pkg::dep_addr(req_r.node);
            cur_nxt       = req_r.node;
            j_nxt         = '0;
            state_nxt     = S_WALK;
          end
        end
      end
      S_LIFT: begin
        cmd.tbl_we    = 1'b1;
        cmd.tbl_waddr = tkal_pkg::slot(req_r.node, j_r);
        cmd.tbl_wdata = rsp.tbl_rdata;
        cmd.tbl_raddr = tkal_pkg::slot(rsp.tbl_rdata, j_r);
        if (j_r == LVL_ONE) begin
          cmd.dep_we    = 1'b1;
          cmd.dep_waddr = tkal_pkg::dep_addr(req_r.node);
          cmd.dep_wdata = dep_new;
        end
        if (j_r == LVL_LAST) begin
          status_nxt = tkal_pkg::ST_LOAD_OK;
          state_nxt  = S_DONE;
        end else begin
          j_nxt = j_r + LVL_ONE;
        end
      end
      S_WALK: begin
        if (j_r == '0 && req_r.steps > rsp.dep_rdata) begin
          status_nxt = tkal_pkg::ST_NONE;
          state_nxt  = S_DONE;
        end else if (j_r == LVL_LAST) begin
          status_nxt = tkal_pkg::ST_FOUND;
          anc_nxt    = cur_eff;
          state_nxt  = S_DONE;
        end else begin
          cmd.tbl_raddr = tkal_pkg::slot(cur_eff, j_r + LVL_ONE);
          cur_nxt       = cur_eff;
          j_nxt         = j_r + LVL_ONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      req_r <= req;
    end
    j_r      <= j_nxt;
    cur_r    <= cur_nxt;
    status_r <= status_nxt;
    anc_r    <= anc_nxt;
  end

endmodule

// File: rtl/tree_kth_ancestor_lifting.sv
// top level of the tree ancestor engine: channels, result register, sequencer
// and store; depends on tkal_pkg, tkal_in_if, tkal_out_if, tkal_ctrl, tkal_store
//
// Binary-lifting k-th ancestor engine, one request at a time. A load (kind 0)
// writes a node's parent as its first lifting entry, fills the remaining
// LEVELS-1 entries with one dependent table read per cycle and stores the
// parent's depth plus one (0 for the root); loads must arrive in index order
// from node 0 up. A query (kind 1) checks steps against the stored depth and
// then climbs one lifting level per cycle. A request passes through the issue
// state, the lift states (loads) or walk states (queries), the done state and
// the output register; a bad load goes from issue straight to done, and a
// query whose step count is beyond the depth ends at its first walk step.
// Each level's table address is the previous level's read data, so the levels
// are read one after another through the single read port of the lifting
// table. The next request is taken once the previous result has moved into
// the output register, which may still wait for out ready.
module tree_kth_ancestor_lifting (
  input  logic       clk,
  input  logic       rst_n,
  tkal_in_if.sink    in_chan,
  tkal_out_if.source out_chan
);

  tkal_pkg::req_t     req;
  tkal_pkg::res_t     res;
  tkal_pkg::mem_cmd_t cmd;
  tkal_pkg::mem_rsp_t rsp;
  logic               req_ready;
  logic               req_fire;
  logic               out_free;

  logic                          out_valid_r;
  logic [tkal_pkg::STATUS_W-1:0] out_status_r;
  logic [tkal_pkg::NODE_W-1:0]   out_anc_r;

  assign req.kind   = in_chan.kind;
  assign req.node   = in_chan.node;
  assign req.parent = in_chan.parent;
  assign req.steps  = in_chan.steps;

  assign in_chan.ready = req_ready;
  assign req_fire      = in_chan.valid && req_ready;
  assign out_free      = !out_valid_r || out_chan.ready;

  tkal_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_fire  (req_fire),
    .req       (req),
    .req_ready (req_ready),
    .out_free  (out_free),
    .res       (res),
    .cmd       (cmd),
    .rsp       (rsp)
  );

  tkal_store u_store (
    .clk (clk),
    .cmd (cmd),
    .rsp (rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res.valid) begin
      out_status_r <= res.status;
      out_anc_r    <= res.ancestor;
    end
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.status   = out_status_r;
  assign out_chan.ancestor = out_anc_r;

endmodule

// File: rtl/tkal_checker.sv
// port-level checker for the tree ancestor engine and its bind to the top level
// depends on tkal_pkg and tree_kth_ancestor_lifting_assert.svh
`include "tree_kth_ancestor_lifting_assert.svh"

module tkal_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [tkal_pkg::STATUS_W-1:0] out_status,
  input logic [tkal_pkg::NODE_W-1:0]   out_ancestor
);

  `TKAL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `TKAL_ASSERT_IMPLY(a_anc_zero, clk, rst_n, out_valid && out_status != tkal_pkg::ST_FOUND, out_ancestor == '0)
  `TKAL_ASSERT_NEXT(a_busy_after_req, clk, rst_n, in_valid && in_ready, !in_ready)
  `TKAL_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_valid)

endmodule

bind tree_kth_ancestor_lifting tkal_checker u_tkal_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_chan.valid),
  .in_ready     (in_chan.ready),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .out_status   (out_chan.status),
  .out_ancestor (out_chan.ancestor)
);

// File: bench/tb_tree_kth_ancestor_lifting.sv
// testbench for the tree ancestor engine: directed cases, then index-order
// loads among ancestor queries and bad loads under varying idle and stall rates
// depends on tkal_pkg, tkal_in_if, tkal_out_if and tree_kth_ancestor_lifting
module tb_tree_kth_ancestor_lifting;
  timeunit 1ns;
  timeprecision 1ps;

  import tkal_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_ITEMS = 500;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [NODE_W-1:0]   ancestor;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n;

  tkal_in_if  req_if ();
  tkal_out_if res_if ();

  tree_kth_ancestor_lifting dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (req_if),
    .out_chan (res_if)
  );

  always #5ns clk = ~clk;

  logic [NODE_W-1:0]  anc_tbl   [NODES][LEVELS];
  logic [DEPTH_W-1:0] depth_mem [NODES];
  int                 loaded_cnt;
  answer_t            answers_due [$];
  int                 mismatches;
  int                 src_idle_pct;
  int                 sink_stall_pct;

  task automatic report_mismatch(input string msg);
    $display("ERROR %0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic req_t make_req(input logic kind, input int node, input int parent,
                                    input int steps);
    req_t r;
    r.kind   = kind;
    r.node   = NODE_W'(node);
    r.parent = NODE_W'(parent);
    r.steps  = STEP_W'(steps);
    return r;
  endfunction

  // climb the tree model for one request and update it for loads
  function automatic answer_t climb_or_load(input req_t r);
    answer_t            a;
    logic [NODE_W-1:0]  v;
    logic [NODE_W-1:0]  p;
    int                 d;
    v = r.node;
    p = r.parent;
    a.ancestor = '0;
    if (r.kind == KIND_LOAD) begin
      if (int'(v) >= NODES || (v != 0 && p >= v)) begin
        a.status = ST_BAD;
        return a;
      end
      if (v == 0) begin
        p = '0;
        d = 0;
      end else begin
        d = int'(depth_mem[p]) + 1;
        if (d > int'(DEPTH_MAX)) d = int'(DEPTH_MAX);
      end
      depth_mem[v] = DEPTH_W'(d);
      anc_tbl[v][0] = p;
      for (int j = 1; j < LEVELS; j++) begin
        anc_tbl[v][j] = anc_tbl[anc_tbl[v][j-1]][j-1];
      end
      if (int'(v) >= loaded_cnt) loaded_cnt = int'(v) + 1;
      a.status = ST_LOAD_OK;
    end else begin
      if (int'(v) >= NODES || int'(r.steps) > int'(depth_mem[v])) begin
        a.status = ST_NONE;
        return a;
      end
      for (int j = 0; j < LEVELS; j++) begin
        if (j < STEP_W && r.steps[j]) v = anc_tbl[v][j];
      end
      a.status   = ST_FOUND;
      a.ancestor = v;
    end
    return a;
  endfunction

  task automatic send_request(input req_t r);
    while ($urandom_range(99, 0) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid  <= 1'b1;
    req_if.kind   <= r.kind;
    req_if.node   <= r.node;
    req_if.parent <= r.parent;
    req_if.steps  <= r.steps;
    @(posedge clk);
    while (req_if.ready !== 1'b1) @(posedge clk);
    answers_due.push_back(climb_or_load(r));
  endtask

  task automatic drain_answers();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (answers_due.size() != 0) @(posedge clk);
  endtask

  function automatic req_t pick_request();
    int sel, v, p, lim, d, k;
    sel = $urandom_range(99, 0);
    if (loaded_cnt < NODES && sel < 48) begin
      v = loaded_cnt;
      sel = $urandom_range(99, 0);
      if (sel < 70) begin
        p = v - 1;
      end else if (sel < 85) begin
        lim = (v - 1 < 7) ? v - 1 : 7;
        p = v - 1 - $urandom_range(lim, 0);
      end else begin
        p = $urandom_range(v - 1, 0);
      end
      return make_req(KIND_LOAD, v, p, $urandom_range(1023, 0));
    end
    if (sel < 88) begin
      if ($urandom_range(4, 0) == 0) v = loaded_cnt - 1;
      else v = $urandom_range(loaded_cnt - 1, 0);
      d = int'(depth_mem[v]);
      sel = $urandom_range(99, 0);
      if (sel < 50)      k = $urandom_range(d, 0);
      else if (sel < 60) k = d;
      else if (sel < 70) k = (d < 1023) ? d + 1 : d;
      else               k = $urandom_range(1023, 0);
      return make_req(KIND_QUERY, v, $urandom_range(1023, 0), k);
    end
    v = $urandom_range(1023, 1);
    p = $urandom_range(1023, v);
    return make_req(KIND_LOAD, v, p, $urandom_range(1023, 0));
  endfunction

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) begin
      send_request(pick_request());
      if ($urandom_range(199, 0) == 0) drain_answers();
    end
  endtask

  task automatic test_directed();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    // root parent is ignored, root queries
    send_request(make_req(KIND_LOAD, 0, 1023, 0));
    send_request(make_req(KIND_QUERY, 0, 0, 0));
    send_request(make_req(KIND_QUERY, 0, 0, 1));
    send_request(make_req(KIND_QUERY, 0, 0, 1023));
    // parent not below node, then a small tree, queries on it and two more bad loads
    send_request(make_req(KIND_LOAD, 1, 1, 0));
    send_request(make_req(KIND_LOAD, 1, 1023, 1023));
    send_request(make_req(KIND_LOAD, 1023, 1023, 0));
    send_request(make_req(KIND_LOAD, 1, 0, 0));
    send_request(make_req(KIND_LOAD, 2, 1, 0));
    send_request(make_req(KIND_LOAD, 3, 2, 0));
    send_request(make_req(KIND_LOAD, 4, 3, 0));
    send_request(make_req(KIND_LOAD, 5, 0, 0));
    send_request(make_req(KIND_QUERY, 4, 0, 4));
    send_request(make_req(KIND_QUERY, 4, 1023, 3));
    send_request(make_req(KIND_QUERY, 4, 0, 5));
    send_request(make_req(KIND_QUERY, 4, 0, 2));
    send_request(make_req(KIND_QUERY, 5, 0, 1));
    send_request(make_req(KIND_QUERY, 3, 0, 0));
    send_request(make_req(KIND_QUERY, 3, 0, 1023));
    send_request(make_req(KIND_LOAD, 6, 6, 0));
    send_request(make_req(KIND_LOAD, 6, 7, 0));
  endtask

  task automatic test_streaming();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    run_random(PHASE_ITEMS);
  endtask

  task automatic test_sender_gaps();
    src_idle_pct   = 59;
    sink_stall_pct = 0;
    run_random(PHASE_ITEMS);
  endtask

  task automatic test_receiver_stalls();
    src_idle_pct   = 0;
    sink_stall_pct = 59;
    run_random(PHASE_ITEMS);
  endtask

  task automatic test_both_idle();
    src_idle_pct   = 23;
    sink_stall_pct = 23;
    run_random(PHASE_ITEMS / 2);
    drain_answers();
    run_random(PHASE_ITEMS / 2);
  endtask

  always @(posedge clk) begin
    answer_t want;
    res_if.ready <= ($urandom_range(99, 0) >= sink_stall_pct);
    if (rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      if (answers_due.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want = answers_due.pop_front();
        if (res_if.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", res_if.status, want.status));
        if (res_if.ancestor !== want.ancestor)
          report_mismatch($sformatf("ancestor %0d, want %0d", res_if.ancestor,
                                    want.ancestor));
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst_n !== 1'b1 || (req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
          (res_if.valid === 1'b1 && res_if.ready === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
    $display("tree_kth_ancestor_lifting: mismatch");
    $finish;
  end

  initial begin
    mismatches     = 0;
    loaded_cnt     = 0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    rst_n         <= 1'b0;
    req_if.valid  <= 1'b0;
    req_if.kind   <= KIND_LOAD;
    req_if.node   <= '0;
    req_if.parent <= '0;
    req_if.steps  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_streaming();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_idle();
    drain_answers();
    repeat (LEVELS + 4) @(posedge clk);
    if (mismatches == 0) begin
      $display("tree_kth_ancestor_lifting: match");
    end else begin
      $display("tree_kth_ancestor_lifting: mismatch");
    end
    $finish;
  end

endmodule
